@@ sv/assert_macros.svh @@
// Assertion helpers; the including scope provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/wdtp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wdtp_pkg;

    localparam int MAX_LEN_DEFAULT = 4096;

    localparam int POS_W    = 12;
    localparam int WIN_W    = 10;
    localparam int PROB_W   = 17;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 2;
    localparam int NUM_BASES = 4;

    // transitions in a window never exceed 2*1023
    localparam int CNT_W = 11;
    localparam int DEN_W = CNT_W + 2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_PAD_W  = OUT_DATA_W - NUM_BASES * PROB_W;

    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_HALF = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_A     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_C     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_G     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_T     = 3'd4;

    localparam logic [WIN_W-1:0]  WINDOW_HALF_RST = 10'd200;
    localparam logic [PROB_W-1:0] PRIOR_A_RST     = 17'd19137;
    localparam logic [PROB_W-1:0] PRIOR_C_RST     = 17'd13500;
    localparam logic [PROB_W-1:0] PRIOR_G_RST     = 17'd13173;
    localparam logic [PROB_W-1:0] PRIOR_T_RST     = 17'd19726;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ sv/wdtp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: quot = (numer << 16) / denom, numer <= denom, one bit per cycle.
module wdtp_div
    import wdtp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DEN_W-1:0]  numer,
    input  wire logic [DEN_W-1:0]  denom,
    output logic                   done,
    output logic [PROB_W-1:0]      quot
);

    localparam int STEP_W = $clog2(PROB_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROB_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [PROB_W-1:0] quot_reg;

    logic [DEN_W:0]    trial;
    logic              ge;

    always_comb
    begin
        if (step_reg == '0)
        begin
            trial = {1'b0, rem_reg};
        end
        else
        begin
            trial = {rem_reg, 1'b0};
        end
        ge = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= numer;
                den_reg  <= denom;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                quot_reg <= {quot_reg[PROB_W-2:0], ge};
                if (ge)
                begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= DEN_W'(trial);
                end
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ sv/windowed_dinucleotide_transition_prob.sv @@
// Windowed order-1 transition probability estimator for DNA bases.
// Slave stream: s_tuser is the request kind (0 append, 1 query); s_tdata
// carries base, first and position. Each transfer yields exactly one
// transfer on the master stream: m_tuser is the status, m_tdata the four
// Q1.16 probabilities (zero unless a query succeeds).
// APB port: window_half at 0x00, prior_a..prior_t at 0x04..0x10; write
// only while no request is in flight. pready is tied high.
// Appends, failed queries and position-zero queries go straight to ST_DONE,
// which loads the output register. A query at position n >= 1 reads the
// row base and scans the T transitions of its window (at most 2*window_half)
// before any divisions: the base store has a single read port, scanned one
// entry per cycle; one serial divider produces a quotient bit per cycle.
// One request is processed at a time; the next is taken once the result is
// in the output register, which holds it while m_tready is low. A stalled
// output only delays the handover of the following result.
// Reset clears the sequence length and loads the register defaults; the
// base store is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module windowed_dinucleotide_transition_prob
    import wdtp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_W-1:0]      pwdata,
    output logic      [APB_W-1:0]      prdata,
    output logic                       pready,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // base[1:0], first[2], position[14:3], pad
    input  wire logic [0:0]            s_tuser,   // req_type[0]

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // prob_a, prob_c, prob_g, prob_t, pad
    output logic [STATUS_W-1:0]        m_tuser    // status[1:0]
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int XW    = ((LEN_W > POS_W + 1) ? LEN_W : POS_W + 1) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_PRIME,
        ST_SCAN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [WIN_W-1:0]    window_half_reg;
    logic [PROB_W-1:0]   prior_reg [NUM_BASES];

    logic [LEN_W-1:0]    len_reg;
    logic [AW-1:0]       lo_reg;
    logic [AW-1:0]       hi_reg;
    logic [AW-1:0]       k_reg;
    logic [BASE_W-1:0]   row_reg;
    logic [BASE_W-1:0]   prev_reg;
    logic [CNT_W-1:0]    cnt_reg [NUM_BASES];
    logic [1:0]          j_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [PROB_W-1:0]   res_prob_reg [NUM_BASES];

    logic                m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [BASE_W-1:0]   mem [MAX_LEN];
    logic [BASE_W-1:0]   rd_data_reg;
    logic [AW-1:0]       rd_addr;

    logic                acc;
    logic                in_req;
    logic [BASE_W-1:0]   in_base;
    logic                in_first;
    logic [POS_W-1:0]    in_pos;

    logic [LEN_W-1:0]    len_eff;
    logic                app_full;
    logic                mem_we;

    logic [XW-1:0]       n_x;
    logic [XW-1:0]       w_x;
    logic [XW-1:0]       len_x;
    logic [XW-1:0]       two_w;
    logic [XW-1:0]       lo_x;
    logic [XW-1:0]       hi_x;

    logic [DEN_W-1:0]    sum;
    logic                div_start;
    logic                div_done;
    logic [PROB_W-1:0]   div_q;

    logic                cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    logic                k_in_window;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_half_reg <= WINDOW_HALF_RST;
            prior_reg[0]    <= PRIOR_A_RST;
            prior_reg[1]    <= PRIOR_C_RST;
            prior_reg[2]    <= PRIOR_G_RST;
            prior_reg[3]    <= PRIOR_T_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WINDOW_HALF: window_half_reg <= pwdata[WIN_W-1:0];
                REG_PRIOR_A:     prior_reg[0]    <= pwdata[PROB_W-1:0];
                REG_PRIOR_C:     prior_reg[1]    <= pwdata[PROB_W-1:0];
                REG_PRIOR_G:     prior_reg[2]    <= pwdata[PROB_W-1:0];
                REG_PRIOR_T:     prior_reg[3]    <= pwdata[PROB_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW_HALF: prdata = APB_W'(window_half_reg);
            REG_PRIOR_A:     prdata = APB_W'(prior_reg[0]);
            REG_PRIOR_C:     prdata = APB_W'(prior_reg[1]);
            REG_PRIOR_G:     prdata = APB_W'(prior_reg[2]);
            REG_PRIOR_T:     prdata = APB_W'(prior_reg[3]);
            default:         prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign in_req   = s_tuser[0];
    assign in_base  = s_tdata[1:0];
    assign in_first = s_tdata[2];
    assign in_pos   = s_tdata[14:3];

    assign len_eff  = in_first ? '0 : len_reg;
    assign app_full = (len_eff >= LEN_W'(MAX_LEN));
    assign mem_we   = acc && (in_req == REQ_APPEND) && !app_full;

    // window bounds, clamped at both ends
    always_comb
    begin
        n_x   = XW'(in_pos);
        w_x   = XW'(window_half_reg);
        len_x = XW'(len_reg);
        two_w = XW'({window_half_reg, 1'b0});
        if (two_w + XW'(1) > len_x)
        begin
            lo_x = '0;
            hi_x = len_x - XW'(1);
        end
        else if (n_x < w_x)
        begin
            lo_x = '0;
            hi_x = two_w;
        end
        else if (n_x + w_x >= len_x)
        begin
            lo_x = len_x - XW'(1) - two_w;
            hi_x = len_x - XW'(1);
        end
        else
        begin
            lo_x = n_x - w_x;
            hi_x = n_x + w_x;
        end
    end

    // ---------------- base store ----------------
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: rd_addr = AW'(n_x - XW'(1));
            ST_ROW:  rd_addr = lo_reg;
            default: rd_addr = k_reg + AW'(1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[len_eff[AW-1:0]] <= in_base;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ---------------- divider ----------------
    assign sum = DEN_W'(cnt_reg[0]) + DEN_W'(cnt_reg[1])
               + DEN_W'(cnt_reg[2]) + DEN_W'(cnt_reg[3]);
    assign div_start = (state_reg == ST_DIV_START) && (sum != '0);

    wdtp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (DEN_W'(cnt_reg[j_reg])),
        .denom (sum),
        .done  (div_done),
        .quot  (div_q)
    );

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            k_reg          <= '0;
            row_reg        <= '0;
            prev_reg       <= '0;
            j_reg          <= '0;
            res_status_reg <= STATUS_OK;
            for (int i = 0; i < NUM_BASES; i++)
            begin
                cnt_reg[i]      <= '0;
                res_prob_reg[i] <= '0;
            end
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= STATUS_OK;
        end
        else
        begin
            // ST_DONE either reloads the output register or leaves it waiting
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        for (int i = 0; i < NUM_BASES; i++)
                        begin
                            cnt_reg[i] <= '0;
                            if ((in_req == REQ_QUERY) && (n_x < len_x) && (in_pos == '0))
                            begin
                                res_prob_reg[i] <= prior_reg[i];
                            end
                            else
                            begin
                                res_prob_reg[i] <= '0;
                            end
                        end
                        state_reg <= ST_DONE;
                        if (in_req == REQ_APPEND)
                        begin
                            if (app_full)
                            begin
                                res_status_reg <= STATUS_FULL;
                                len_reg        <= len_eff;
                            end
                            else
                            begin
                                res_status_reg <= STATUS_OK;
                                len_reg        <= len_eff + LEN_W'(1);
                            end
                        end
                        else if (n_x >= len_x)
                        begin
                            res_status_reg <= STATUS_RANGE;
                        end
                        else if (in_pos == '0)
                        begin
                            res_status_reg <= STATUS_OK;
                        end
                        else
                        begin
                            res_status_reg <= STATUS_OK;
                            lo_reg         <= AW'(lo_x);
                            hi_reg         <= AW'(hi_x);
                            state_reg      <= ST_ROW;
                        end
                    end
                end

                ST_ROW:
                begin
                    row_reg   <= rd_data_reg;
                    k_reg     <= lo_reg;
                    state_reg <= ST_PRIME;
                end

                ST_PRIME:
                begin
                    prev_reg <= rd_data_reg;
                    j_reg    <= '0;
                    if (k_reg == hi_reg)
                    begin
                        state_reg <= ST_DIV_START;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_SCAN;
                    end
                end

                ST_SCAN:
                begin
                    if (prev_reg == row_reg)
                    begin
                        cnt_reg[rd_data_reg] <= cnt_reg[rd_data_reg] + CNT_W'(1);
                    end
                    prev_reg <= rd_data_reg;
                    if (k_reg == hi_reg)
                    begin
                        state_reg <= ST_DIV_START;
                    end
                    else
                    begin
                        k_reg <= k_reg + AW'(1);
                    end
                end

                ST_DIV_START:
                begin
                    if (sum == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end

                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        res_prob_reg[j_reg] <= div_q;
                        if (j_reg == 2'd3)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end

                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= {{OUT_PAD_W{1'b0}}, res_prob_reg[3], res_prob_reg[2],
                                         res_prob_reg[1], res_prob_reg[0]};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks ----------------
    assign k_in_window = (k_reg > lo_reg) && (k_reg <= hi_reg);

    `ASSERT_ALWAYS(a_len_bound, len_reg <= LEN_W'(MAX_LEN), "sequence length beyond store")
    `ASSERT_IMPLIES(a_scan_range, state_reg == ST_SCAN, k_in_window, "scan index out of window")
    `ASSERT_IMPLIES(a_div_done_wait, div_done, state_reg == ST_DIV_WAIT, "stray divider done")

endmodule

`default_nettype wire

@@ dv/windowed_dinucleotide_transition_prob_tb.sv @@
`timescale 1ns / 1ps

module windowed_dinucleotide_transition_prob_tb;
    import wdtp_pkg::*;

    localparam int STALL_LIMIT = 12000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN   = 40;

    typedef struct packed {
        logic [STATUS_W-1:0]                  status;
        logic [NUM_BASES-1:0][PROB_W-1:0]     prob;   // [0] A .. [3] T
    } prob_result_t;

    class prob_scoreboard;
        logic [BASE_W-1:0] seq_bases [MAX_LEN_DEFAULT];
        int unsigned       seq_len;
        logic [WIN_W-1:0]  win_half;
        logic [PROB_W-1:0] prior [NUM_BASES];
        prob_result_t      expected_q [$];
        int                errors;
        int                results_seen;

        function new();
            seq_len = 0;
            win_half = WINDOW_HALF_RST;
            prior[0] = PRIOR_A_RST;
            prior[1] = PRIOR_C_RST;
            prior[2] = PRIOR_G_RST;
            prior[3] = PRIOR_T_RST;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_W-1:0] value);
            case (idx)
                REG_WINDOW_HALF: win_half = value[WIN_W-1:0];
                REG_PRIOR_A:     prior[0] = value[PROB_W-1:0];
                REG_PRIOR_C:     prior[1] = value[PROB_W-1:0];
                REG_PRIOR_G:     prior[2] = value[PROB_W-1:0];
                REG_PRIOR_T:     prior[3] = value[PROB_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [PROB_W-1:0] q16_ratio(int unsigned num, int unsigned den);
            logic [63:0] q;
            if (den == 0)
                return '0;
            q = (64'(num) << 16) / 64'(den);
            return q[PROB_W-1:0];
        endfunction

        // window of 2W transitions around n, clamped at both ends; the whole sequence if shorter
        function prob_result_t transition_probs(int unsigned n);
            prob_result_t      r;
            int unsigned       w;
            int unsigned       lo;
            int unsigned       hi;
            int unsigned       pre;
            int unsigned       suf;
            int unsigned       sum;
            int unsigned       cnt [NUM_BASES];
            logic [BASE_W-1:0] row;
            w = win_half;
            lo = 0;
            hi = seq_len - 1;
            for (int j = 0; j < NUM_BASES; j++)
                cnt[j] = 0;
            if (2 * w + 1 <= seq_len) begin
                pre = w;
                suf = w;
                if (n < w) begin
                    pre = n;
                    suf = 2 * w - n;
                end
                else if (n + w >= seq_len) begin
                    suf = seq_len - 1 - n;
                    pre = 2 * w - suf;
                end
                lo = n - pre;
                hi = n + suf;
            end
            row = seq_bases[n - 1];
            for (int unsigned k = lo; k < hi; k++)
                if (seq_bases[k] == row)
                    cnt[seq_bases[k + 1]]++;
            sum = cnt[0] + cnt[1] + cnt[2] + cnt[3];
            r = '0;
            r.status = STATUS_OK;
            for (int j = 0; j < NUM_BASES; j++)
                r.prob[j] = q16_ratio(cnt[j], sum);
            return r;
        endfunction

        function void note_request(logic req, logic [BASE_W-1:0] b, logic first,
                                   logic [POS_W-1:0] pos);
            prob_result_t e;
            e = '0;
            if (req == REQ_APPEND) begin
                if (first)
                    seq_len = 0;
                if (seq_len >= MAX_LEN_DEFAULT)
                    e.status = STATUS_FULL;
                else begin
                    seq_bases[seq_len] = b;
                    seq_len++;
                    e.status = STATUS_OK;
                end
            end
            else if (pos >= seq_len)
                e.status = STATUS_RANGE;
            else if (pos == 0) begin
                e.status = STATUS_OK;
                for (int j = 0; j < NUM_BASES; j++)
                    e.prob[j] = prior[j];
            end
            else
                e = transition_probs(pos);
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: result %0d mismatch: %s", $time, results_seen, msg);
        endtask

        task check_result(prob_result_t got);
            prob_result_t e;
            results_seen++;
            if (expected_q.size() == 0) begin
                report("result transfer with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status)
                report($sformatf("status got %0d expected %0d", got.status, e.status));
            for (int j = 0; j < NUM_BASES; j++)
                if (got.prob[j] !== e.prob[j])
                    report($sformatf("prob[%0d] got %0d expected %0d",
                                     j, got.prob[j], e.prob[j]));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_W-1:0]      pwdata = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // base[1:0], first[2], position[14:3], pad[15]
    logic [0:0]            s_tuser = '0;    // req_type[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // prob_a, prob_c, prob_g, prob_t, pad
    logic [STATUS_W-1:0]   m_tuser;         // status[1:0]

    prob_scoreboard sb;
    bit             steady = 1'b0;
    bit             hold_off_req = 1'b0;
    int unsigned    gen_len = 0;
    int unsigned    idle_cycles = 0;

    windowed_dinucleotide_transition_prob dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tuser[0], s_tdata[1:0], s_tdata[2], s_tdata[14:3]);
    end

    always @(posedge clk) begin
        prob_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tuser;
            for (int j = 0; j < NUM_BASES; j++)
                got.prob[j] = m_tdata[j*PROB_W +: PROB_W];
            sb.check_result(got);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result side: per-transfer stall, plus one long hold-off on request
    initial begin
        int unsigned wait_cycles;
        forever begin
            wait_cycles = steady ? 0 : $urandom_range(0, 11);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (wait_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send(logic req, logic [BASE_W-1:0] b, logic first, logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {1'b0, pos, first, b};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (req == REQ_APPEND) begin
            if (first)
                gen_len = 1;
            else if (gen_len < MAX_LEN_DEFAULT)
                gen_len++;
        end
    endtask

    task automatic append(logic [BASE_W-1:0] b, logic first);
        send(REQ_APPEND, b, first, POS_W'($urandom));
    endtask

    task automatic query(int unsigned pos);
        send(REQ_QUERY, BASE_W'($urandom), 1'($urandom), POS_W'(pos));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(int unsigned w, int unsigned pa, int unsigned pc,
                             int unsigned pg, int unsigned pt);
        drain();
        apb_write(REG_WINDOW_HALF, w);
        apb_write(REG_PRIOR_A, pa);
        apb_write(REG_PRIOR_C, pc);
        apb_write(REG_PRIOR_G, pg);
        apb_write(REG_PRIOR_T, pt);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gen_len == 0 || r < 3)
            append(BASE_W'($urandom), 1'b1);
        else if (r < 8)
            query($urandom_range(0, 4095));
        else if (r < 10)
            query(0);
        else if (r < 55)
            append(BASE_W'($urandom), 1'b0);
        else
            query($urandom_range(0, gen_len - 1));
    endtask

    // a fresh sequence, then mixed appends and queries
    task automatic random_phase(int items, int seed_len, bit with_hold);
        append(BASE_W'($urandom), 1'b1);
        repeat (seed_len - 1) append(BASE_W'($urandom), 1'b0);
        for (int i = 0; i < items; i++) begin
            if (i == 30)
                steady = 1'b1;
            if (i == 60)
                steady = 1'b0;
            if (with_hold && i == 80)
                hold_off_req = 1'b1;
            random_item();
        end
    endtask

    task automatic random_priors_phase(bit with_hold);
        int unsigned w;
        case ($urandom_range(0, 3))
            0: w = $urandom_range(1, 8);
            1: w = $urandom_range(9, 64);
            2: w = WINDOW_HALF_RST;
            default: w = $urandom_range(65, 400);
        endcase
        configure(w, $urandom_range(0, 65536), $urandom_range(0, 65536),
                  $urandom_range(0, 65536), $urandom_range(0, 65536));
        random_phase(140, $urandom_range(10, 150), with_hold);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults
        query(0);
        append(2'd0, 1'b1);
        append(2'd1, 1'b0);
        append(2'd2, 1'b0);
        append(2'd3, 1'b0);
        append(2'd3, 1'b0);
        append(2'd2, 1'b0);
        append(2'd1, 1'b0);
        append(2'd0, 1'b0);
        append(2'd2, 1'b0);
        append(2'd2, 1'b0);
        query(0);
        query(1);
        query(5);
        query(9);
        query(10);
        query(4095);
        append(2'd3, 1'b1);
        query(1);
        query(0);
        append(2'd1, 1'b0);
        query(1);

        configure(1, 0, 65536, 65536, 0);
        random_phase(140, 40, 1'b0);

        // sequence shorter than the window: every transition counts
        configure(1023, 65536, 0, 0, 65536);
        random_phase(140, 200, 1'b0);

        // zero window: rows are empty
        configure(0, 65536, 65536, 65536, 65536);
        append(BASE_W'($urandom), 1'b1);
        repeat (9) append(BASE_W'($urandom), 1'b0);
        for (int p = 0; p < 6; p++)
            query(p);

        random_priors_phase(1'b1);
        repeat (2) random_priors_phase(1'b0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/wdtp_pkg.sv
sv/wdtp_div.sv
sv/windowed_dinucleotide_transition_prob.sv
dv/windowed_dinucleotide_transition_prob_tb.sv
